// ===== design/msd_pkg.sv =====
// Shared types and constants for the marker-framed sample deframer.
// Holds the command format passed from the front end to the back end.
// No dependencies.
package msd_pkg;

   typedef enum logic [2:0] {
      OP_PING,
      OP_ACK,
      OP_RATE,
      OP_DIAG,
      OP_ERR,
      OP_UNK,
      OP_BURST
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [15:0] word;
   } cmd_type;

   localparam logic [2:0] KIND_SAMPLE  = 3'd0;
   localparam logic [2:0] KIND_PONG    = 3'd1;
   localparam logic [2:0] KIND_ACK     = 3'd2;
   localparam logic [2:0] KIND_RATE    = 3'd3;
   localparam logic [2:0] KIND_DIAG    = 3'd4;
   localparam logic [2:0] KIND_CHK_ERR = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN = 3'd6;

   localparam logic [7:0] TYPE_PING = 8'hC0;
   localparam logic [7:0] TYPE_PONG = 8'hC1;
   localparam logic [7:0] TYPE_ACK  = 8'hC2;
   localparam logic [7:0] TYPE_RATE = 8'hC3;
   localparam logic [7:0] TYPE_DIAG = 8'hC4;

   localparam logic [7:0] CSR_FRAME_MARKER = 8'd0;
   localparam logic [7:0] CSR_GAIN_COMMAND = 8'd1;

endpackage

// ===== design/msd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 30,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/msd_front.sv =====
// Front end: takes received bytes, tracks the frame, checks XOR sums and
// stores samples into the sample RAM. Emits commands; depends on msd_pkg.
module msd_front import msd_pkg::*; #(
   parameter int SAMPLES = 30,
   localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_rx_byte,
   input  logic [7:0]    frame_marker,
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd,
   input  logic          burst_done,
   output logic          ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [23:0]   ram_wdata
);

   localparam int DATA_LEN = 5 + 3 * SAMPLES;
   localparam int PW = $clog2(DATA_LEN);
   localparam logic [PW-1:0] CHECK_POS = PW'(DATA_LEN - 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in;
   logic [15:0]   lo_ff, lo_in;
   logic [1:0]    lane_ff, lane_in;
   logic [AW-1:0] sidx_ff, sidx_in;
   logic          busy_ff, busy_in;
   logic          accept, is_data, in_samples;
   logic [7:0]    rx;

   assign rx         = req_rx_byte;
   assign is_data    = (type_ff == 8'(SAMPLES));
   assign in_samples = is_data && (pos_ff >= PW'(4)) && (pos_ff < CHECK_POS);
   assign req_ready  = !q_full && !(busy_ff && in_samples);
   assign accept     = req_valid && req_ready;

   assign ram_we    = accept && in_samples && (lane_ff == 2'd2);
   assign ram_waddr = sidx_ff;
   assign ram_wdata = {rx, lo_ff};

   always_comb begin
      pos_in   = pos_ff;
      type_in  = type_ff;
      first_in = first_ff;
      xor_in   = xor_ff;
      b2_in    = b2_ff;
      b3_in    = b3_ff;
      b4_in    = b4_ff;
      lo_in    = lo_ff;
      lane_in  = lane_ff;
      sidx_in  = sidx_ff;
      q_push   = 1'b0;
      q_cmd    = '{op: OP_ERR, a: type_ff, b: 8'h00, c: 8'h00, word: 16'h0000};

      if (accept) begin
         xor_in = xor_ff ^ rx;
         if (pos_ff == '0) begin
            if (rx == frame_marker) begin
               first_in = rx;
               pos_in   = PW'(1);
            end
         end else if (pos_ff == PW'(1)) begin
            type_in = rx;
            xor_in  = rx;
            lane_in = 2'd0;
            sidx_in = '0;
            pos_in  = PW'(2);
            if (rx == 8'(SAMPLES)) begin
               pos_in = PW'(2);
            end else if (rx == TYPE_PING) begin
               q_push   = 1'b1;
               q_cmd.op = OP_PING;
               pos_in   = '0;
            end else if (rx == TYPE_ACK || rx == TYPE_RATE || rx == TYPE_DIAG) begin
               pos_in = PW'(2);
            end else begin
               q_push   = 1'b1;
               q_cmd.op = OP_UNK;
               q_cmd.a  = rx;
               pos_in   = '0;
            end
         end else begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(2)) b2_in = rx;
            if (pos_ff == PW'(3)) b3_in = rx;
            if (pos_ff == PW'(4)) b4_in = rx;
            if (is_data) begin
               if (in_samples) begin
                  case (lane_ff)
                     2'd0: begin
                        lo_in[7:0] = rx;
                        lane_in    = 2'd1;
                     end
                     2'd1: begin
                        lo_in[15:8] = rx;
                        lane_in     = 2'd2;
                     end
                     default: begin
                        lane_in = 2'd0;
                        sidx_in = sidx_ff + AW'(1);
                     end
                  endcase
               end
               if (pos_ff == CHECK_POS) begin
                  pos_in = '0;
                  q_push = 1'b1;
                  if ((xor_ff ^ first_ff) == rx) begin
                     q_cmd.op   = OP_BURST;
                     q_cmd.word = {b3_ff, b2_ff};
                  end
               end
            end else if (type_ff == TYPE_ACK || type_ff == TYPE_RATE) begin
               if (pos_ff == PW'(4)) begin
                  pos_in = '0;
                  if (xor_ff != rx) begin
                     q_push = 1'b1;
                  end else if (type_ff == TYPE_ACK) begin
                     q_push   = 1'b1;
                     q_cmd.op = OP_ACK;
                     q_cmd.a  = b2_ff;
                     q_cmd.b  = b3_ff;
                  end else if ({b3_ff, b2_ff} != 16'h0000) begin
                     q_push     = 1'b1;
                     q_cmd.op   = OP_RATE;
                     q_cmd.word = {b3_ff, b2_ff};
                  end
               end
            end else if (pos_ff == PW'(5)) begin
               pos_in = '0;
               q_push = 1'b1;
               if (xor_ff == rx) begin
                  q_cmd.op = OP_DIAG;
                  q_cmd.a  = b2_ff;
                  q_cmd.b  = b3_ff;
                  q_cmd.c  = b4_ff;
               end
            end
         end
      end

      busy_in = busy_ff;
      if (q_push && q_cmd.op == OP_BURST) busy_in = 1'b1;
      if (burst_done) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
      end
      type_ff  <= type_in;
      first_ff <= first_in;
      xor_ff   <= xor_in;
      b2_ff    <= b2_in;
      b3_ff    <= b3_in;
      b4_ff    <= b4_in;
      lo_ff    <= lo_in;
      lane_ff  <= lane_in;
      sidx_ff  <= sidx_in;
   end

   // samples of a frame still draining must not be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !busy_ff)
      else $error("sample RAM written while previous burst pending");

   a_burst_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_cmd.op == OP_BURST) |=> busy_ff)
      else $error("burst queued without busy flag");

endmodule

// ===== design/msd_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on msd_pkg for the command type.
module msd_queue import msd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   input  logic    pop,
   output cmd_type cmd_out,
   output logic    full,
   output logic    empty
);

   cmd_type    ent_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign cmd_out = ent_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
      if (push) begin
         ent_ff[wr_ff] <= cmd_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != 2'd0))
      else $error("command queue underflow");

endmodule

// ===== design/msd_back.sv =====
// Back end: carries out queued commands, reads samples back from RAM and
// drives the registered result channel. Depends on msd_pkg.
module msd_back import msd_pkg::*; #(
   parameter int SAMPLES = 30,
   localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   input  logic [7:0]         frame_marker,
   input  logic [7:0]         gain_command_code,
   output logic [AW-1:0]      ram_raddr,
   input  logic [23:0]        ram_rdata,
   output logic               burst_done,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [15:0]        rsp_seq_number,
   output logic signed [23:0] rsp_sample_value,
   output logic signed [15:0] rsp_sample_low16,
   output logic [7:0]         rsp_gain_code,
   output logic [7:0]         rsp_byte_a,
   output logic [7:0]         rsp_byte_b,
   output logic [7:0]         rsp_byte_c,
   output logic [15:0]        rsp_rate_value,
   output logic               rsp_last_flag
);

   typedef enum logic [1:0] {ST_IDLE, ST_PONG, ST_READ, ST_SEND} state_type;

   state_type     state_ff, state_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [15:0]   bseq_ff, bseq_in;
   logic [7:0]    gain_ff, gain_in;

   logic          valid_ff;
   logic [2:0]    kind_ff;
   logic [15:0]   seq_ff;
   logic [23:0]   value_ff;
   logic [7:0]    gout_ff, a_ff, b_ff, c_ff;
   logic [15:0]   rate_ff;
   logic          last_ff;

   logic          out_free, ld, last_sample;
   logic [2:0]    o_kind;
   logic [15:0]   o_seq, o_rate;
   logic [23:0]   o_val;
   logic [7:0]    o_gain, o_a, o_b, o_c;
   logic          o_last;

   assign out_free    = !valid_ff || rsp_ready;
   assign ram_raddr   = idx_ff;
   assign last_sample = (idx_ff == AW'(SAMPLES - 1));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      bseq_in    = bseq_ff;
      gain_in    = gain_ff;
      q_pop      = 1'b0;
      burst_done = 1'b0;
      ld         = 1'b0;
      o_kind     = KIND_SAMPLE;
      o_seq      = 16'h0000;
      o_val      = 24'h000000;
      o_gain     = 8'h00;
      o_a        = 8'h00;
      o_b        = 8'h00;
      o_c        = 8'h00;
      o_rate     = 16'h0000;
      o_last     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  OP_PING: begin
                     ld       = 1'b1;
                     o_kind   = KIND_PONG;
                     o_a      = frame_marker;
                     o_last   = 1'b0;
                     cnt_in   = 2'd1;
                     state_in = ST_PONG;
                  end
                  OP_ACK: begin
                     ld     = 1'b1;
                     o_kind = KIND_ACK;
                     o_a    = q_cmd.a;
                     o_b    = q_cmd.b;
                     if (q_cmd.a == gain_command_code) gain_in = q_cmd.b;
                  end
                  OP_RATE: begin
                     ld     = 1'b1;
                     o_kind = KIND_RATE;
                     o_rate = q_cmd.word;
                  end
                  OP_DIAG: begin
                     ld     = 1'b1;
                     o_kind = KIND_DIAG;
                     o_a    = q_cmd.a;
                     o_b    = q_cmd.b;
                     o_c    = q_cmd.c;
                  end
                  OP_ERR: begin
                     ld     = 1'b1;
                     o_kind = KIND_CHK_ERR;
                     o_a    = q_cmd.a;
                  end
                  OP_UNK: begin
                     ld     = 1'b1;
                     o_kind = KIND_UNKNOWN;
                     o_a    = q_cmd.a;
                  end
                  OP_BURST: begin
                     bseq_in  = q_cmd.word;
                     idx_in   = '0;
                     state_in = ST_READ;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_PONG: begin
            if (out_free) begin
               ld     = 1'b1;
               o_kind = KIND_PONG;
               cnt_in = cnt_ff + 2'd1;
               case (cnt_ff)
                  2'd1: begin
                     o_a    = TYPE_PONG;
                     o_last = 1'b0;
                  end
                  2'd2: begin
                     o_a    = 8'h00;
                     o_last = 1'b0;
                  end
                  default: begin
                     o_a      = TYPE_PONG;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               ld     = 1'b1;
               o_kind = KIND_SAMPLE;
               o_seq  = bseq_ff;
               o_val  = ram_rdata;
               o_gain = gain_ff;
               o_last = last_sample;
               if (last_sample) begin
                  burst_done = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         gain_ff  <= 8'h00;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
         if (ld) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      bseq_ff <= bseq_in;
      if (ld) begin
         kind_ff  <= o_kind;
         seq_ff   <= o_seq;
         value_ff <= o_val;
         gout_ff  <= o_gain;
         a_ff     <= o_a;
         b_ff     <= o_b;
         c_ff     <= o_c;
         rate_ff  <= o_rate;
         last_ff  <= o_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_seq_number   = seq_ff;
   assign rsp_sample_value = value_ff;
   assign rsp_sample_low16 = value_ff[15:0];
   assign rsp_gain_code    = gout_ff;
   assign rsp_byte_a       = a_ff;
   assign rsp_byte_b       = b_ff;
   assign rsp_byte_c       = c_ff;
   assign rsp_rate_value   = rate_ff;
   assign rsp_last_flag    = last_ff;

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      burst_done |=> (valid_ff && last_ff && kind_ff == KIND_SAMPLE))
      else $error("burst finished without final sample result");

endmodule

// ===== design/marker_framed_sample_deframer.sv =====
// Marker-framed sample deframer, top level.
// Holds the configuration registers and joins front end, command queue,
// sample RAM and back end. Depends on msd_pkg and all msd_* modules.
//
// req_ channel: one received serial byte per request (req_rx_byte).
// rsp_ channel: one result per transfer; a byte causes none, one or several,
// last_flag marking the final one. csr_ channel: index 0 frame marker,
// index 1 gain command code; other indexes are ignored. csr_ready is high.
// A single result (ack, rate, diag, error, unknown type) passes through the
// command queue and then the result register; a ping gives 4 pong results,
// one per cycle while rsp_ready is high; a checked data frame gives SAMPLES
// results, each taking a read state for the registered read of the sample
// RAM and then a send state.
// The front end keeps taking bytes while results drain; it holds
// req_ready low only when the two-entry command queue is full or when a
// new frame reaches its sample bytes before the previous frame's samples
// have all been read out.
// Reset clears frame position, queue, gain and result valid; the sample
// RAM has no reset and needs no clearing pass. When rsp_ready is low the
// result register holds and the queue absorbs further commands.
module marker_framed_sample_deframer import msd_pkg::*; #(
   parameter int SAMPLES = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [15:0]        rsp_seq_number,
   output logic signed [23:0] rsp_sample_value,
   output logic signed [15:0] rsp_sample_low16,
   output logic [7:0]         rsp_gain_code,
   output logic [7:0]         rsp_byte_a,
   output logic [7:0]         rsp_byte_b,
   output logic [7:0]         rsp_byte_c,
   output logic [15:0]        rsp_rate_value,
   output logic               rsp_last_flag,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

   logic [7:0]    marker_ff, gain_cmd_ff;
   logic          q_push, q_pop, q_full, q_empty, burst_done;
   cmd_type       push_cmd, head_cmd;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [23:0]   ram_wdata, ram_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff   <= 8'hAB;
         gain_cmd_ff <= 8'h00;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_MARKER: marker_ff   <= csr_wdata;
            CSR_GAIN_COMMAND: gain_cmd_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   msd_front #(.SAMPLES(SAMPLES)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .frame_marker (marker_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd),
      .burst_done   (burst_done),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata)
   );

   msd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .pop     (q_pop),
      .cmd_out (head_cmd),
      .full    (q_full),
      .empty   (q_empty)
   );

   msd_ram #(.WIDTH(24), .DEPTH(SAMPLES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   msd_back #(.SAMPLES(SAMPLES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (head_cmd),
      .q_pop             (q_pop),
      .frame_marker      (marker_ff),
      .gain_command_code (gain_cmd_ff),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata),
      .burst_done        (burst_done),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_seq_number    (rsp_seq_number),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_sample_low16  (rsp_sample_low16),
      .rsp_gain_code     (rsp_gain_code),
      .rsp_byte_a        (rsp_byte_a),
      .rsp_byte_b        (rsp_byte_b),
      .rsp_byte_c        (rsp_byte_c),
      .rsp_rate_value    (rsp_rate_value),
      .rsp_last_flag     (rsp_last_flag)
   );

endmodule
